[hw/rtl/mrh_pkg.sv]
// mrh_pkg: types, codes, constants and the crc-16 step shared by the
// modbus read-holding master; no dependencies
`timescale 1ns / 1ps

package mrh_pkg;

   localparam int MAX_FRAME_BYTES_DEF = 256;
   localparam int MAX_REGS_DEF        = 16;
   localparam int COUNT_LIMIT         = 16;
   localparam int MIN_FRAME           = 5;
   localparam logic [7:0]  FUNC_READ  = 8'h03;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SLAVE_ADDRESS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_REGISTER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REGISTER_COUNT = 2'd2;

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_BYTE    = 2'd1,
      OP_GAP     = 2'd2,
      OP_TIMEOUT = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_TX     = 2'd0,
      KIND_REG    = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_COUNT = 3'd1,
      ST_TIMEOUT   = 3'd2,
      ST_SHORT     = 3'd3,
      ST_ADDR_FUNC = 3'd4,
      ST_LENGTH    = 3'd5,
      ST_CRC       = 3'd6
   } status_type;

   // sequencer strobes into the frame receiver
   typedef struct packed {
      logic start;
      logic rx_en;
      logic close;
   } frame_ctl_type;

   // frame receiver state as seen by the sequencer
   typedef struct packed {
      logic       awaiting;
      logic       pos_zero;
      logic       overflow;
      status_type verdict;
   } frame_stat_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic count_ok(input logic [4:0] rc, input int max_regs);
      return (rc != 5'd0) && (32'(rc) <= 32'(COUNT_LIMIT)) && (32'(rc) <= 32'(max_regs));
   endfunction

endpackage

[hw/rtl/mrh_if.sv]
// mrh_if: valid/ready channel interfaces for request and response words
// depends on nothing
`timescale 1ns / 1ps

interface mrh_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] rx_byte;
   modport source(output valid, output op, output rx_byte, input ready);
   modport sink(input valid, input op, input rx_byte, output ready);
endinterface

interface mrh_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] data;
   logic [3:0]  reg_index;
   logic [2:0]  status;
   logic        last;
   logic [31:0] tx_total;
   logic [31:0] rx_total;
   logic [31:0] err_total;
   modport source(output valid, output kind, output data, output reg_index, output status,
                  output last, output tx_total, output rx_total, output err_total,
                  input ready);
   modport sink(input valid, input kind, input data, input reg_index, input status,
                input last, input tx_total, input rx_total, input err_total,
                output ready);
endinterface

[hw/rtl/mrh_ram.sv]
// mrh_ram: generic single-write, single-read ram with registered read
// depends on nothing
`timescale 1ns / 1ps

module mrh_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/mrh_frame.sv]
// mrh_frame: reply frame receiver - byte position, running crc, header capture,
// register word writes and the end-of-frame verdict; depends on mrh_pkg
`timescale 1ns / 1ps

module mrh_frame #(
   parameter int MAX_FRAME_BYTES = mrh_pkg::MAX_FRAME_BYTES_DEF,
   parameter int MAX_REGS        = mrh_pkg::MAX_REGS_DEF,
   localparam int STORE_DEPTH    = (MAX_REGS < 16) ? MAX_REGS : 16,
   localparam int AW             = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mrh_pkg::frame_ctl_type   ctl,
   input  logic [7:0]               rx_byte,
   input  logic [7:0]               slave_address,
   input  logic [4:0]               register_count,
   output mrh_pkg::frame_stat_type  stat,
   output logic                     wr_en,
   output logic [AW-1:0]            wr_addr,
   output logic [15:0]              wr_data
);
   import mrh_pkg::*;

   localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

   logic          awaiting_ff, awaiting_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    hdr_addr_ff, hdr_addr_in;
   logic [7:0]    hdr_func_ff, hdr_func_in;
   logic [7:0]    hdr_count_ff, hdr_count_in;
   logic [15:0]   crc_end_ff, crc_end_in;
   logic [15:0]   crc_rx_ff, crc_rx_in;
   logic [7:0]    hi_ff, hi_in;
   logic [PW-1:0] off;
   logic          overflow;
   status_type    verdict;

   assign overflow = 32'(pos_ff) >= 32'(MAX_FRAME_BYTES);
   assign off      = pos_ff - PW'(3);

   always_comb begin
      awaiting_in  = awaiting_ff;
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      hdr_addr_in  = hdr_addr_ff;
      hdr_func_in  = hdr_func_ff;
      hdr_count_in = hdr_count_ff;
      crc_end_in   = crc_end_ff;
      crc_rx_in    = crc_rx_ff;
      hi_in        = hi_ff;
      wr_en        = 1'b0;
      wr_addr      = AW'(off >> 1);
      wr_data      = {hi_ff, rx_byte};

      if (ctl.start) begin
         awaiting_in = 1'b1;
         pos_in      = '0;
         crc_in      = CRC_INIT;
      end else if (ctl.close) begin
         awaiting_in = 1'b0;
         pos_in      = '0;
      end else if (ctl.rx_en && !overflow) begin
         if (pos_ff == PW'(0)) begin
            hdr_addr_in = rx_byte;
         end else if (pos_ff == PW'(1)) begin
            hdr_func_in = rx_byte;
         end else if (pos_ff == PW'(2)) begin
            hdr_count_in = rx_byte;
         end else if (16'(off) < 16'(hdr_count_ff)) begin
            // high byte waits, the whole word goes in with the low byte
            if (!off[0]) begin
               hi_in = rx_byte;
            end else if (16'(off >> 1) < 16'(STORE_DEPTH)) begin
               wr_en = 1'b1;
            end
         end else if (16'(off) == 16'(hdr_count_ff)) begin
            crc_end_in = crc_ff;
            crc_rx_in  = {8'h00, rx_byte};
         end else if (16'(off) == 16'(hdr_count_ff) + 16'd1) begin
            crc_rx_in = {rx_byte, crc_rx_ff[7:0]};
         end
         crc_in = crc_feed(crc_ff, rx_byte);
         pos_in = pos_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff  <= 1'b0;
         pos_ff       <= '0;
         crc_ff       <= CRC_INIT;
         hdr_addr_ff  <= '0;
         hdr_func_ff  <= '0;
         hdr_count_ff <= '0;
         crc_end_ff   <= '0;
         crc_rx_ff    <= '0;
      end else begin
         awaiting_ff  <= awaiting_in;
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         hdr_addr_ff  <= hdr_addr_in;
         hdr_func_ff  <= hdr_func_in;
         hdr_count_ff <= hdr_count_in;
         crc_end_ff   <= crc_end_in;
         crc_rx_ff    <= crc_rx_in;
      end
      hi_ff <= hi_in;
   end

   // end-of-frame checks in priority order
   always_comb begin
      if (32'(pos_ff) < 32'(MIN_FRAME)) begin
         verdict = ST_SHORT;
      end else if (hdr_addr_ff != slave_address || hdr_func_ff != FUNC_READ) begin
         verdict = ST_ADDR_FUNC;
      end else if (!count_ok(register_count, MAX_REGS)) begin
         verdict = ST_BAD_COUNT;
      end else if (hdr_count_ff != {2'b00, register_count, 1'b0} ||
                   16'(pos_ff) < 16'(hdr_count_ff) + 16'd5) begin
         verdict = ST_LENGTH;
      end else if (crc_end_ff != crc_rx_ff) begin
         verdict = ST_CRC;
      end else begin
         verdict = ST_OK;
      end
   end

   assign stat.verdict  = verdict;
   assign stat.awaiting = awaiting_ff;
   assign stat.pos_zero = (pos_ff == '0);
   assign stat.overflow = overflow;

endmodule

[hw/rtl/modbus_rtu_read_holding_master.sv]
// modbus_rtu_read_holding_master: top level - command sequencer, request
// builder, counters and response register; depends on mrh_pkg, mrh_if,
// mrh_frame and mrh_ram
`timescale 1ns / 1ps

// Modbus RTU master for read holding registers (function 0x03).
// req_ch carries one command word per handshake: start, received byte,
// inter-frame gap or response timeout. rsp_ch carries result words: the
// eight request bytes, the register values of a good reply, or one status.
// Every result word carries the three running counters after its command.
// csr_we/csr_index/csr_wdata write slave_address, first_register and
// register_count; write them only while the block is idle.
// Received bytes are taken in the idle state and yield no result word. A
// start sends the request bytes, the request crc being built a byte a cycle
// as the bytes leave while the receiver takes them. A good reply is read back
// from the register ram a word at a time (read address, then registered read
// data); an error ends in a single status word.
// A stalled receiver holds the response register and the sequencer with it;
// a command that yields no result is still taken while a word waits.
// Reset is synchronous and active high: idle, counters zero, not waiting for a
// reply. The register ram is not cleared; a good reply rewrites every word
// that it reports.

module modbus_rtu_read_holding_master #(
   parameter int MAX_FRAME_BYTES = mrh_pkg::MAX_FRAME_BYTES_DEF,
   parameter int MAX_REGS        = mrh_pkg::MAX_REGS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   mrh_req_if.sink                         req_ch,
   mrh_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [mrh_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mrh_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mrh_pkg::*;

   localparam int STORE_DEPTH = (MAX_REGS < 16) ? MAX_REGS : 16;
   localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_TX      = 5'b00010,
      S_STAT    = 5'b00100,
      S_RD_ADDR = 5'b01000,
      S_RD_DATA = 5'b10000
   } state_type;

   // configuration registers
   logic [7:0]  slave_address_ff;
   logic [15:0] first_register_ff;
   logic [4:0]  register_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff  <= 8'd1;
         first_register_ff <= 16'd0;
         register_count_ff <= 5'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SLAVE_ADDRESS:  slave_address_ff  <= csr_wdata[7:0];
            CSR_FIRST_REGISTER: first_register_ff <= csr_wdata[15:0];
            CSR_REGISTER_COUNT: register_count_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // sequencer and counters
   state_type   state_ff, state_in;
   logic [2:0]  tx_cnt_ff, tx_cnt_in;
   logic [15:0] tx_crc_ff, tx_crc_in;
   logic [3:0]  rd_idx_ff, rd_idx_in;
   status_type  stat_code_ff, stat_code_in;
   logic [31:0] sent_ff, sent_in;
   logic [31:0] good_ff, good_in;
   logic [31:0] err_ff, err_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    rsp_kind_ff, rsp_kind_in;
   logic [15:0] rsp_data_ff, rsp_data_in;
   logic [3:0]  rsp_index_ff, rsp_index_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [31:0] rsp_tx_ff, rsp_rx_ff, rsp_err_ff;
   logic        rsp_load;

   frame_ctl_type  fctl;
   frame_stat_type fstat;
   logic           ram_we;
   logic [AW-1:0]  ram_waddr;
   logic [15:0]    ram_wdata;
   logic [15:0]    ram_rdata;

   logic       accept;
   op_type     op;
   logic       load_ok;
   logic [7:0] tx_byte;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign op           = op_type'(req_ch.op);
   assign load_ok      = !rsp_valid_ff || rsp_ch.ready;

   // request byte under the transmit pointer
   always_comb begin
      case (tx_cnt_ff)
         3'd0:    tx_byte = slave_address_ff;
         3'd1:    tx_byte = FUNC_READ;
         3'd2:    tx_byte = first_register_ff[15:8];
         3'd3:    tx_byte = first_register_ff[7:0];
         3'd4:    tx_byte = 8'h00;
         3'd5:    tx_byte = {3'b000, register_count_ff};
         3'd6:    tx_byte = tx_crc_ff[7:0];
         default: tx_byte = tx_crc_ff[15:8];
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      tx_cnt_in     = tx_cnt_ff;
      tx_crc_in     = tx_crc_ff;
      rd_idx_in     = rd_idx_ff;
      stat_code_in  = stat_code_ff;
      sent_in       = sent_ff;
      good_in       = good_ff;
      err_in        = err_ff;
      fctl          = '0;
      rsp_load      = 1'b0;
      rsp_kind_in   = KIND_STATUS;
      rsp_data_in   = 16'h0000;
      rsp_index_in  = 4'd0;
      rsp_status_in = ST_OK;
      rsp_last_in   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (op)
                  OP_START: begin
                     if (count_ok(register_count_ff, MAX_REGS)) begin
                        fctl.start = 1'b1;
                        sent_in    = sent_ff + 32'd1;
                        tx_cnt_in  = 3'd0;
                        tx_crc_in  = CRC_INIT;
                        state_in   = S_TX;
                     end else begin
                        // rejected request leaves the pending transaction alone
                        stat_code_in = ST_BAD_COUNT;
                        state_in     = S_STAT;
                     end
                  end
                  OP_BYTE: begin
                     if (fstat.awaiting) begin
                        if (fstat.overflow) begin
                           err_in = err_ff + 32'd1;
                        end else begin
                           fctl.rx_en = 1'b1;
                        end
                     end
                  end
                  OP_GAP: begin
                     if (fstat.awaiting && !fstat.pos_zero) begin
                        fctl.close = 1'b1;
                        if (fstat.verdict == ST_OK) begin
                           good_in   = good_ff + 32'd1;
                           rd_idx_in = 4'd0;
                           state_in  = S_RD_ADDR;
                        end else begin
                           err_in       = err_ff + 32'd1;
                           stat_code_in = fstat.verdict;
                           state_in     = S_STAT;
                        end
                     end
                  end
                  OP_TIMEOUT: begin
                     if (fstat.awaiting) begin
                        fctl.close   = 1'b1;
                        err_in       = err_ff + 32'd1;
                        stat_code_in = ST_TIMEOUT;
                        state_in     = S_STAT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_TX: begin
            if (load_ok) begin
               rsp_load    = 1'b1;
               rsp_kind_in = KIND_TX;
               rsp_data_in = {8'h00, tx_byte};
               rsp_last_in = (tx_cnt_ff == 3'd7);
               // crc runs over the six header bytes as they leave
               if (tx_cnt_ff < 3'd6) begin
                  tx_crc_in = crc_feed(tx_crc_ff, tx_byte);
               end
               tx_cnt_in = tx_cnt_ff + 3'd1;
               if (tx_cnt_ff == 3'd7) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_STAT: begin
            if (load_ok) begin
               rsp_load      = 1'b1;
               rsp_kind_in   = KIND_STATUS;
               rsp_status_in = stat_code_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_RD_ADDR: begin
            // ram address is rd_idx; data is valid in the cycle after, in S_RD_DATA
            state_in = S_RD_DATA;
         end
         S_RD_DATA: begin
            if (load_ok) begin
               rsp_load     = 1'b1;
               rsp_kind_in  = KIND_REG;
               rsp_data_in  = ram_rdata;
               rsp_index_in = rd_idx_ff;
               rsp_last_in  = ({1'b0, rd_idx_ff} + 5'd1 == register_count_ff);
               if (rsp_last_in) begin
                  state_in = S_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + 4'd1;
                  state_in  = S_RD_ADDR;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sent_ff      <= '0;
         good_ff      <= '0;
         err_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sent_ff      <= sent_in;
         good_ff      <= good_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tx_cnt_ff    <= tx_cnt_in;
      tx_crc_ff    <= tx_crc_in;
      rd_idx_ff    <= rd_idx_in;
      stat_code_ff <= stat_code_in;
      if (rsp_load) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_tx_ff     <= sent_ff;
         rsp_rx_ff     <= good_ff;
         rsp_err_ff    <= err_ff;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.kind      = rsp_kind_ff;
   assign rsp_ch.data      = rsp_data_ff;
   assign rsp_ch.reg_index = rsp_index_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.last      = rsp_last_ff;
   assign rsp_ch.tx_total  = rsp_tx_ff;
   assign rsp_ch.rx_total  = rsp_rx_ff;
   assign rsp_ch.err_total = rsp_err_ff;

   // reply frame receiver
   mrh_frame #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
      .MAX_REGS        (MAX_REGS)
   ) u_frame (
      .clock          (clock),
      .reset          (reset),
      .ctl            (fctl),
      .rx_byte        (req_ch.rx_byte),
      .slave_address  (slave_address_ff),
      .register_count (register_count_ff),
      .stat           (fstat),
      .wr_en          (ram_we),
      .wr_addr        (ram_waddr),
      .wr_data        (ram_wdata)
   );

   // register word store
   mrh_ram #(
      .WIDTH (16),
      .DEPTH (STORE_DEPTH)
   ) u_regs (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

endmodule

[tb/tb_top.sv]
// tb_top: self-checking bench for the modbus read-holding master, with a
// command driver, a result monitor and a cycle-free model of the master
// depends on mrh_pkg, mrh_if and modbus_rtu_read_holding_master
`timescale 1ns / 1ps

module tb_top;
   import mrh_pkg::*;

   localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake at all
   localparam int SETTLE_WAIT  = 40;    // covers the longest busy stretch
   localparam int RANDOM_ITEMS = 220;

   typedef struct {
      op_type     op;
      logic [7:0] rx_byte;
   } command_type;

   typedef struct {
      kind_type    kind;
      logic [15:0] data;
      logic [3:0]  reg_index;
      status_type  status;
      logic        last;
      logic [31:0] tx_total;
      logic [31:0] rx_total;
      logic [31:0] err_total;
   } result_word_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   mrh_req_if req_ch();
   mrh_rsp_if rsp_ch();

   modbus_rtu_read_holding_master dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // ---------------------------------------------------------------
   // shadow of the master: configuration, receive state and counters
   // ---------------------------------------------------------------
   logic [7:0]  cfg_slave;
   logic [15:0] cfg_first;
   logic [4:0]  cfg_count;

   logic        link_waiting;
   int          rx_pos;
   logic [15:0] rx_crc;
   logic [7:0]  hdr_addr;
   logic [7:0]  hdr_func;
   logic [7:0]  hdr_bytes;
   logic [15:0] crc_at_end;
   logic [15:0] crc_in_frame;
   logic [15:0] reg_copy [MAX_REGS_DEF];
   logic [31:0] cnt_sent;
   logic [31:0] cnt_good;
   logic [31:0] cnt_err;

   result_word_type awaited_words[$];  // result words still to come, oldest first
   command_type     pending_cmds[$];   // commands not yet offered to the block

   int  fail_count;
   int  words_seen;
   int  queued_items;
   int  quiet_cycles;
   bit  req_pace;
   bit  rsp_pace;

   // modbus crc-16, lsb first, one bit of the byte at a time
   function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
      logic fb;
      for (int i = 0; i < 8; i++) begin
         fb  = crc[0] ^ b[i];
         crc = crc >> 1;
         if (fb) begin
            crc = crc ^ CRC_POLY;
         end
      end
      return crc;
   endfunction

   function automatic bit count_in_range();
      return cfg_count >= 5'd1 && int'(cfg_count) <= COUNT_LIMIT &&
             int'(cfg_count) <= MAX_REGS_DEF;
   endfunction

   // every word carries the counters as they stand after its command
   function automatic void push_word(kind_type k, logic [15:0] d, logic [3:0] idx,
                                     status_type st, logic lst);
      result_word_type w;
      w.kind      = k;
      w.data      = d;
      w.reg_index = idx;
      w.status    = st;
      w.last      = lst;
      w.tx_total  = cnt_sent;
      w.rx_total  = cnt_good;
      w.err_total = cnt_err;
      awaited_words.push_back(w);
   endfunction

   // any ending of the reply other than success
   function automatic void reply_fails(status_type st);
      cnt_err++;
      link_waiting = 1'b0;
      rx_pos       = 0;
      push_word(KIND_STATUS, 16'h0000, 4'd0, st, 1'b1);
   endfunction

   function automatic void reset_shadow();
      cfg_slave    = 8'd1;
      cfg_first    = 16'd0;
      cfg_count    = 5'd1;
      link_waiting = 1'b0;
      rx_pos       = 0;
      rx_crc       = CRC_INIT;
      hdr_addr     = 8'd0;
      hdr_func     = 8'd0;
      hdr_bytes    = 8'd0;
      crc_at_end   = 16'd0;
      crc_in_frame = 16'd0;
      cnt_sent     = 32'd0;
      cnt_good     = 32'd0;
      cnt_err      = 32'd0;
   endfunction

   // expected words for one accepted command
   function automatic void predict_command(command_type c);
      logic [7:0]  frame [8];
      logic [15:0] crc;
      int          bc;
      int          off;
      int          idx;
      bc = int'(hdr_bytes);
      case (c.op)
         OP_START: begin
            if (!count_in_range()) begin
               push_word(KIND_STATUS, 16'h0000, 4'd0, ST_BAD_COUNT, 1'b1);
            end else begin
               frame[0] = cfg_slave;
               frame[1] = FUNC_READ;
               frame[2] = cfg_first[15:8];
               frame[3] = cfg_first[7:0];
               frame[4] = 8'h00;
               frame[5] = {3'b000, cfg_count};
               crc = CRC_INIT;
               for (int i = 0; i < 6; i++) begin
                  crc = crc16_step(crc, frame[i]);
               end
               frame[6] = crc[7:0];
               frame[7] = crc[15:8];
               // a start while waiting simply drops the old exchange
               link_waiting = 1'b1;
               rx_pos       = 0;
               rx_crc       = CRC_INIT;
               cnt_sent++;
               for (int i = 0; i < 8; i++) begin
                  push_word(KIND_TX, {8'h00, frame[i]}, 4'd0, ST_OK, i == 7);
               end
            end
         end
         OP_BYTE: begin
            if (!link_waiting) begin
               // ignored while idle
            end else if (rx_pos >= MAX_FRAME_BYTES_DEF) begin
               cnt_err++;  // frame overflow, byte dropped silently
            end else begin
               if (rx_pos == 0) begin
                  hdr_addr = c.rx_byte;
               end else if (rx_pos == 1) begin
                  hdr_func = c.rx_byte;
               end else if (rx_pos == 2) begin
                  hdr_bytes = c.rx_byte;
               end else begin
                  off = rx_pos - 3;
                  if (off < bc) begin
                     idx = off >> 1;
                     if (idx < MAX_REGS_DEF) begin
                        if (off % 2 == 0) begin
                           reg_copy[idx] = {c.rx_byte, 8'h00};
                        end else begin
                           reg_copy[idx] = reg_copy[idx] | {8'h00, c.rx_byte};
                        end
                     end
                  end else if (off == bc) begin
                     crc_at_end   = rx_crc;
                     crc_in_frame = {8'h00, c.rx_byte};
                  end else if (off == bc + 1) begin
                     crc_in_frame = crc_in_frame | {c.rx_byte, 8'h00};
                  end
               end
               rx_crc = crc16_step(rx_crc, c.rx_byte);
               rx_pos++;
            end
         end
         OP_GAP: begin
            if (!link_waiting || rx_pos == 0) begin
               // nothing received yet, gap ignored
            end else if (rx_pos < MIN_FRAME) begin
               reply_fails(ST_SHORT);
            end else if (hdr_addr != cfg_slave || hdr_func != FUNC_READ) begin
               reply_fails(ST_ADDR_FUNC);
            end else if (!count_in_range()) begin
               reply_fails(ST_BAD_COUNT);
            end else if (bc != 2 * int'(cfg_count) || rx_pos < bc + 5) begin
               reply_fails(ST_LENGTH);
            end else if (crc_at_end != crc_in_frame) begin
               reply_fails(ST_CRC);
            end else begin
               cnt_good++;
               link_waiting = 1'b0;
               rx_pos       = 0;
               for (int i = 0; i < int'(cfg_count); i++) begin
                  push_word(KIND_REG, reg_copy[i], 4'(i), ST_OK, i + 1 == int'(cfg_count));
               end
            end
         end
         default: begin
            if (link_waiting) begin
               reply_fails(ST_TIMEOUT);
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------
   task automatic report_mismatch(string msg);
      fail_count++;
      if (fail_count <= 40) begin
         $display("%0t mismatch: %s", $realtime, msg);
      end
   endtask

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         report_mismatch($sformatf("word %0d %s expected %h got %h",
                                   words_seen, name, want, got));
      end
   endtask

   task automatic check_word();
      result_word_type w;
      if (awaited_words.size() == 0) begin
         report_mismatch($sformatf("word %0d unexpected, kind %0d data %h status %0d",
                                   words_seen, rsp_ch.kind, rsp_ch.data, rsp_ch.status));
      end else begin
         w = awaited_words.pop_front();
         compare_field("kind", 32'(w.kind), 32'(rsp_ch.kind));
         compare_field("data", 32'(w.data), 32'(rsp_ch.data));
         compare_field("reg_index", 32'(w.reg_index), 32'(rsp_ch.reg_index));
         compare_field("status", 32'(w.status), 32'(rsp_ch.status));
         compare_field("last", 32'(w.last), 32'(rsp_ch.last));
         compare_field("tx_total", w.tx_total, rsp_ch.tx_total);
         compare_field("rx_total", w.rx_total, rsp_ch.rx_total);
         compare_field("err_total", w.err_total, rsp_ch.err_total);
      end
      words_seen++;
   endtask

   // mostly short pauses, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // ---------------------------------------------------------------
   // command driver: offers queued commands, predicts on acceptance
   // ---------------------------------------------------------------
   command_type in_flight;
   int          hold_off;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         hold_off = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_command(in_flight);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (hold_off > 0) begin
               hold_off--;
               req_ch.valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               in_flight = pending_cmds.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.op      <= in_flight.op;
               req_ch.rx_byte <= in_flight.rx_byte;
               hold_off = req_pace ? idle_len() : 0;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // result monitor: random back-pressure, checks every word taken
   // ---------------------------------------------------------------
   int stall_left;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_word();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (rsp_pace && $urandom_range(0, 99) < 25) begin
               stall_left = idle_len();
            end
         end
      end
   end

   // watchdog: a run with no handshake for too long is hung
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("[modbus_rtu_read_holding_master] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return 8'h00;
      end
      if (r == 1) begin
         return 8'hFF;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void queue_cmd(op_type op, logic [7:0] b);
      command_type c;
      c.op      = op;
      c.rx_byte = b;
      pending_cmds.push_back(c);
      queued_items++;
   endfunction

   // reply frame: header, payload, crc (optionally spoilt), trailing bytes, gap
   function automatic void queue_reply(logic [7:0] addr, logic [7:0] func, logic [7:0] bc,
                                       int payload, bit bad_crc, int trail);
      logic [7:0]  frame[$];
      logic [15:0] crc;
      frame.push_back(addr);
      frame.push_back(func);
      frame.push_back(bc);
      for (int i = 0; i < payload; i++) begin
         frame.push_back(pick_byte());
      end
      crc = CRC_INIT;
      foreach (frame[i]) begin
         crc = crc16_step(crc, frame[i]);
      end
      if (bad_crc) begin
         crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      end
      frame.push_back(crc[7:0]);
      frame.push_back(crc[15:8]);
      for (int i = 0; i < trail; i++) begin
         frame.push_back(pick_byte());
      end
      foreach (frame[i]) begin
         queue_cmd(OP_BYTE, frame[i]);
      end
      queue_cmd(OP_GAP, pick_byte());
   endfunction

   // registers change only on an edge, with the block otherwise quiet
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_SLAVE_ADDRESS:  cfg_slave = value[7:0];
         CSR_FIRST_REGISTER: cfg_first = value;
         CSR_REGISTER_COUNT: cfg_count = value[4:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // drain everything, then let the block finish any word-less command
   task automatic settle();
      while (pending_cmds.size() != 0 || req_ch.valid || awaited_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   function automatic logic [4:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         return 5'd0;
      end
      if (r < 20) begin
         return 5'd16;
      end
      if (r < 75) begin
         return 5'($urandom_range(1, 4));
      end
      return 5'($urandom_range(5, 15));
   endfunction

   // one exchange of a random flavour, built on the current configuration
   task automatic run_exchange();
      int         r;
      int         n;
      int         k;
      logic [7:0] bc;
      logic [7:0] alt;
      r  = $urandom_range(0, 99);
      n  = (cfg_count == 5'd0 || cfg_count > 5'd16) ? 1 : int'(cfg_count);
      bc = 8'(2 * n);
      if (r < 45) begin
         queue_cmd(OP_START, pick_byte());
         queue_reply(cfg_slave, FUNC_READ, bc, int'(bc), 1'b0,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
      end else if (r < 52) begin
         // slave address off by one bit
         queue_cmd(OP_START, pick_byte());
         alt = cfg_slave ^ (8'h01 << $urandom_range(0, 7));
         queue_reply(alt, FUNC_READ, bc, int'(bc), 1'b0, 0);
      end else if (r < 56) begin
         // exception reply or another function
         queue_cmd(OP_START, pick_byte());
         alt = ($urandom_range(0, 1) == 0) ? 8'h83 : pick_byte();
         if (alt == FUNC_READ) begin
            alt = 8'h04;
         end
         queue_reply(cfg_slave, alt, bc, int'(bc), 1'b0, 0);
      end else if (r < 63) begin
         // byte count not twice the register count
         queue_cmd(OP_START, pick_byte());
         alt = 8'($urandom_range(0, 40));
         if (alt == bc) begin
            alt = bc + 8'd1;
         end
         queue_reply(cfg_slave, FUNC_READ, alt, int'(alt), 1'b0, 0);
      end else if (r < 68) begin
         // payload cut short
         queue_cmd(OP_START, pick_byte());
         queue_reply(cfg_slave, FUNC_READ, bc, $urandom_range(0, int'(bc) - 1), 1'b0, 0);
      end else if (r < 75) begin
         queue_cmd(OP_START, pick_byte());
         queue_reply(cfg_slave, FUNC_READ, bc, int'(bc), 1'b1, 0);
      end else if (r < 80) begin
         // fewer than five bytes before the gap
         queue_cmd(OP_START, pick_byte());
         k = $urandom_range(1, 4);
         for (int i = 0; i < k; i++) begin
            queue_cmd(OP_BYTE, (i == 0) ? cfg_slave : pick_byte());
         end
         queue_cmd(OP_GAP, pick_byte());
      end else if (r < 85) begin
         queue_cmd(OP_START, pick_byte());
         k = $urandom_range(0, 5);
         for (int i = 0; i < k; i++) begin
            queue_cmd(OP_BYTE, pick_byte());
         end
         queue_cmd(OP_TIMEOUT, pick_byte());
      end else if (r < 90) begin
         // restart part-way through a reply
         queue_cmd(OP_START, pick_byte());
         k = $urandom_range(0, 6);
         for (int i = 0; i < k; i++) begin
            queue_cmd(OP_BYTE, pick_byte());
         end
         queue_cmd(OP_START, pick_byte());
         queue_reply(cfg_slave, FUNC_READ, bc, int'(bc), 1'b0, 0);
      end else if (r < 95) begin
         // register change while the reply is awaited; checks use the new values
         queue_cmd(OP_START, pick_byte());
         settle();
         if ($urandom_range(0, 1) == 0) begin
            write_csr(CSR_REGISTER_COUNT, {11'($urandom), pick_count()});
         end else begin
            write_csr(CSR_SLAVE_ADDRESS, {8'($urandom), pick_byte()});
         end
         n  = (cfg_count == 5'd0 || cfg_count > 5'd16) ? 1 : int'(cfg_count);
         bc = 8'(2 * n);
         queue_reply(cfg_slave, FUNC_READ, bc, int'(bc), 1'b0, 0);
      end else begin
         // loose commands of any kind
         k = $urandom_range(1, 4);
         for (int i = 0; i < k; i++) begin
            queue_cmd(op_type'($urandom_range(0, 3)), pick_byte());
         end
      end
   endtask

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------
   int random_goal;
   int r_sel;

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_SLAVE_ADDRESS;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.op      = OP_START;
      req_ch.rx_byte = 8'h00;
      rsp_ch.ready   = 1'b0;
      fail_count     = 0;
      words_seen     = 0;
      queued_items   = 0;
      quiet_cycles   = 0;
      req_pace       = 1'b1;
      rsp_pace       = 1'b1;
      reset_shadow();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // idle commands are dropped; then a plain exchange on reset values
      queue_cmd(OP_TIMEOUT, 8'h00);
      queue_cmd(OP_GAP, 8'hFF);
      queue_cmd(OP_BYTE, 8'hA5);
      queue_cmd(OP_START, 8'h5A);
      queue_cmd(OP_GAP, 8'h00);  // gap before any byte is ignored
      queue_reply(8'h01, FUNC_READ, 8'h02, 2, 1'b0, 0);
      queue_cmd(OP_START, 8'h00);
      queue_cmd(OP_TIMEOUT, 8'hFF);
      // start while waiting, then a frame shorter than five bytes
      queue_cmd(OP_START, 8'h00);
      queue_cmd(OP_BYTE, 8'h01);
      queue_cmd(OP_START, 8'h00);
      queue_cmd(OP_BYTE, 8'h01);
      queue_cmd(OP_BYTE, 8'h03);
      queue_cmd(OP_BYTE, 8'h02);
      queue_cmd(OP_BYTE, 8'hFF);
      queue_cmd(OP_GAP, 8'h00);
      settle();

      // top of every register range: a good reply, then the function, address, crc and length checks once each
      write_csr(CSR_SLAVE_ADDRESS, 16'hFFFF);
      write_csr(CSR_FIRST_REGISTER, 16'hFFFF);
      write_csr(CSR_REGISTER_COUNT, 16'h0010);
      queue_cmd(OP_START, 8'h00);
      queue_reply(8'hFF, FUNC_READ, 8'd32, 32, 1'b0, 0);
      queue_cmd(OP_START, 8'h00);
      queue_reply(8'hFF, 8'h83, 8'd32, 32, 1'b0, 0);
      queue_cmd(OP_START, 8'h00);
      queue_reply(8'hFE, FUNC_READ, 8'd32, 32, 1'b0, 0);
      queue_cmd(OP_START, 8'h00);
      queue_reply(8'hFF, FUNC_READ, 8'd32, 32, 1'b1, 0);
      queue_cmd(OP_START, 8'h00);
      queue_reply(8'hFF, FUNC_READ, 8'd31, 31, 1'b0, 0);
      settle();

      // bottom of the ranges: zero count refused at start, and at the gap
      write_csr(CSR_SLAVE_ADDRESS, 16'h0000);
      write_csr(CSR_FIRST_REGISTER, 16'h0000);
      write_csr(CSR_REGISTER_COUNT, 16'h0000);
      queue_cmd(OP_START, 8'h00);
      settle();
      write_csr(CSR_REGISTER_COUNT, 16'h0002);
      queue_cmd(OP_START, 8'h00);
      settle();
      write_csr(CSR_REGISTER_COUNT, 16'hFFE0);
      queue_reply(8'h00, FUNC_READ, 8'd4, 4, 1'b0, 0);
      settle();

      // overflow past the frame store still ends well; then a cut payload
      write_csr(CSR_REGISTER_COUNT, 16'h0001);
      queue_cmd(OP_START, 8'h00);
      queue_reply(8'h00, FUNC_READ, 8'd2, 2, 1'b0, MAX_FRAME_BYTES_DEF + 4 - 7);
      queue_cmd(OP_START, 8'h00);
      queue_reply(8'h00, FUNC_READ, 8'd2, 1, 1'b0, 0);
      settle();

      // random phases: fresh configuration and pacing, a few exchanges each
      random_goal = queued_items + RANDOM_ITEMS;
      while (queued_items < random_goal) begin
         r_sel = $urandom_range(0, 9);
         if (r_sel < 2) begin
            write_csr(CSR_SLAVE_ADDRESS, {8'($urandom), (r_sel == 0) ? 8'h00 : 8'hFF});
         end else begin
            write_csr(CSR_SLAVE_ADDRESS, {8'($urandom), pick_byte()});
         end
         r_sel = $urandom_range(0, 9);
         if (r_sel < 2) begin
            write_csr(CSR_FIRST_REGISTER, (r_sel == 0) ? 16'h0000 : 16'hFFFF);
         end else begin
            write_csr(CSR_FIRST_REGISTER, 16'($urandom));
         end
         write_csr(CSR_REGISTER_COUNT, {11'($urandom), pick_count()});
         // about one phase in four runs flat out on a side
         req_pace = ($urandom_range(0, 3) != 0);
         rsp_pace = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(2, 5)) run_exchange();
         settle();
      end

      settle();
      if (fail_count == 0) begin
         $display("[modbus_rtu_read_holding_master] OK");
      end else begin
         $display("[modbus_rtu_read_holding_master] ERROR");
      end
      $finish;
   end

endmodule
